FILE: hdl/phc_pkg.sv
package phc_pkg;

  localparam int PIX_W    = 8;
  localparam int TGT_W    = 3 * PIX_W;
  localparam int FRAC_W   = 10;
  localparam int HUE_W    = FRAC_W + 3;
  localparam int SCL_W    = FRAC_W + 1;
  localparam int NUM_W    = 11;
  localparam int LO_W     = 3;
  localparam int SUM_W    = 18;
  localparam int RECIP_W  = 19;
  localparam int LPROD_W  = SUM_W + RECIP_W;
  localparam int FPROD_W  = 2 * SCL_W - 1;
  localparam int VPROD_W  = PIX_W + SCL_W;

  // Quotient bits per divider stage; the front end does one more.
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = 4;

  localparam logic [SCL_W-1:0] HUE_ONE = 11'd1024;

  // Rec. 601 luma weights, scaled by 1000, with rounding offset.
  localparam logic [SUM_W-1:0] K_R      = 18'd299;
  localparam logic [SUM_W-1:0] K_G      = 18'd587;
  localparam logic [SUM_W-1:0] K_B      = 18'd114;
  localparam logic [SUM_W-1:0] LUMA_RND = 18'd500;

  // ceil(2^28 / 1000): exact floor(sum / 1000) for every sum below 2^18.
  localparam logic [RECIP_W-1:0] LUMA_RECIP = 19'd268436;
  localparam int                 LUMA_SHIFT = 28;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Hue sextants.
  localparam logic [2:0] SXT_RED_YEL = 3'd0;
  localparam logic [2:0] SXT_YEL_GRN = 3'd1;
  localparam logic [2:0] SXT_GRN_CYN = 3'd2;
  localparam logic [2:0] SXT_CYN_BLU = 3'd3;
  localparam logic [2:0] SXT_BLU_MAG = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] tdl;
    logic [NUM_W-1:0] tnum;
    logic             grey;
  } front_t;

  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic             grey;
    logic [SUM_W-1:0] luma_sum;
    logic [PIX_W-1:0] tdl;
    logic [PIX_W-1:0] hrem;
    logic [LO_W-1:0]  hlo;
    logic [HUE_W-1:0] hq;
    logic [PIX_W-1:0] srem;
    logic [LO_W-1:0]  slo;
    logic [HUE_W-1:0] sq;
  } div_t;

  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic             grey;
    logic [PIX_W-1:0] luma;
    logic [2:0]       sext;
    logic [SCL_W-1:0] ap;
    logic [SCL_W-1:0] aq;
    logic [SCL_W-1:0] at;
  } rebuild_t;

  // One restoring step for both the hue and the saturation quotient.
  function automatic div_t div_advance(div_t x);
    div_t             y;
    logic [PIX_W:0]   hs;
    logic [PIX_W:0]   ss;
    y  = x;
    hs = {x.hrem, x.hlo[LO_W-1]};
    ss = {x.srem, x.slo[LO_W-1]};
    if (hs >= {1'b0, x.tdl}) begin
      y.hrem = PIX_W'(hs - {1'b0, x.tdl});
      y.hq   = {x.hq[HUE_W-2:0], 1'b1};
    end else begin
      y.hrem = hs[PIX_W-1:0];
      y.hq   = {x.hq[HUE_W-2:0], 1'b0};
    end
    if (ss >= {1'b0, x.mx}) begin
      y.srem = PIX_W'(ss - {1'b0, x.mx});
      y.sq   = {x.sq[HUE_W-2:0], 1'b1};
    end else begin
      y.srem = ss[PIX_W-1:0];
      y.sq   = {x.sq[HUE_W-2:0], 1'b0};
    end
    y.hlo = {x.hlo[LO_W-2:0], 1'b0};
    y.slo = {x.slo[LO_W-2:0], 1'b0};
    return y;
  endfunction

endpackage

FILE: hdl/phc_in_if.sv
interface phc_in_if;
  import phc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

FILE: hdl/phc_out_if.sv
interface phc_out_if;
  import phc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  output ready);
endinterface

FILE: hdl/phc_front.sv
module phc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [phc_pkg::TGT_W-1:0] target,
  phc_in_if.sink                    in_ch,
  output logic                      dn_valid,
  output phc_pkg::div_t             dn_data,
  input  logic                      dn_ready
);
  import phc_pkg::*;

  logic             v1_r, v2_r;
  logic             rdy1, rdy2;
  front_t           s1_nxt, s1_r;
  div_t             s2_nxt, s2_r;
  logic [PIX_W-1:0] r, g, b, tr, tg, tb;
  logic [PIX_W-1:0] rg_mx, rg_mn, tmx, tmn, tdl, dl;
  logic [NUM_W-1:0] tdl6;

  assign rdy2        = !v2_r || dn_ready;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  assign r  = in_ch.in_red;
  assign g  = in_ch.in_green;
  assign b  = in_ch.in_blue;
  assign tr = target[3*PIX_W-1:2*PIX_W];
  assign tg = target[2*PIX_W-1:PIX_W];
  assign tb = target[PIX_W-1:0];

  // Stage 1: extremes of the pixel, hue numerator of the target.
  always_comb begin
    rg_mx        = (r > g) ? r : g;
    rg_mn        = (r < g) ? r : g;
    s1_nxt.red   = r;
    s1_nxt.green = g;
    s1_nxt.blue  = b;
    s1_nxt.mx    = (rg_mx > b) ? rg_mx : b;
    s1_nxt.mn    = (rg_mn < b) ? rg_mn : b;
    tmx          = (tr > tg) ? tr : tg;
    tmx          = (tmx > tb) ? tmx : tb;
    tmn          = (tr < tg) ? tr : tg;
    tmn          = (tmn < tb) ? tmn : tb;
    tdl          = tmx - tmn;
    tdl6         = {1'b0, tdl, 2'b00} + {2'b00, tdl, 1'b0};
    s1_nxt.tdl   = tdl;
    s1_nxt.grey  = (tr == tg) && (tg == tb);
    if (tmx == tr) begin
      if (tg >= tb) begin
        s1_nxt.tnum = {3'b000, tg} - {3'b000, tb};
      end else begin
        // wrap a negative red-sextant numerator by six sextants
        s1_nxt.tnum = tdl6 + {3'b000, tg} - {3'b000, tb};
      end
    end else if (tmx == tg) begin
      s1_nxt.tnum = {2'b00, tdl, 1'b0} + {3'b000, tb} - {3'b000, tr};
    end else begin
      s1_nxt.tnum = {1'b0, tdl, 2'b00} + {3'b000, tr} - {3'b000, tg};
    end
  end

  // Stage 2: luma sum, divider setup and the first quotient bit.
  always_comb begin
    div_t x;
    dl         = s1_r.mx - s1_r.mn;
    x.mx       = s1_r.mx;
    x.mn       = s1_r.mn;
    x.grey     = s1_r.grey;
    x.luma_sum = K_R * {{(SUM_W-PIX_W){1'b0}}, s1_r.red}
               + K_G * {{(SUM_W-PIX_W){1'b0}}, s1_r.green}
               + K_B * {{(SUM_W-PIX_W){1'b0}}, s1_r.blue}
               + LUMA_RND;
    x.tdl      = s1_r.tdl;
    x.hrem     = s1_r.tnum[NUM_W-1:LO_W];
    x.hlo      = s1_r.tnum[LO_W-1:0];
    x.hq       = '0;
    x.srem     = {{LO_W{1'b0}}, dl[PIX_W-1:LO_W]};
    x.slo      = dl[LO_W-1:0];
    x.sq       = '0;
    s2_nxt     = div_advance(x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)        s2_r <= s2_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

endmodule

FILE: hdl/phc_div_stage.sv
module phc_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  phc_pkg::div_t up_data,
  output logic          up_ready,
  output logic          dn_valid,
  output phc_pkg::div_t dn_data,
  input  logic          dn_ready
);
  import phc_pkg::*;

  logic v_r;
  div_t d_nxt, d_r;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    d_nxt = up_data;
    for (int i = 0; i < DIV_STEPS; i++) begin
      d_nxt = div_advance(d_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

FILE: hdl/phc_rebuild.sv
module phc_rebuild (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  phc_pkg::div_t up_data,
  output logic          up_ready,
  phc_out_if.source     out_ch
);
  import phc_pkg::*;

  logic               v7_r, v8_r;
  logic               rdy7, rdy8;
  rebuild_t           s7_nxt, s7_r;
  logic [SCL_W-1:0]   sat, fc;
  logic [FRAC_W-1:0]  f;
  logic [FPROD_W-1:0] sf, sfc;
  logic [LPROD_W-1:0] lprod;
  logic [VPROD_W-1:0] pp, qp, tp;
  logic [PIX_W-1:0]   p, q, t, v;
  logic [PIX_W-1:0]   red_nxt, green_nxt, blue_nxt;
  logic [PIX_W-1:0]   red_r, green_r, blue_r;

  assign rdy8     = !v8_r || out_ch.ready;
  assign rdy7     = !v7_r || rdy8;
  assign up_ready = rdy7;

  // Stage 7: hue fraction times saturation, luma by reciprocal.
  always_comb begin
    sat           = up_data.sq[SCL_W-1:0];
    f             = up_data.hq[FRAC_W-1:0];
    fc            = HUE_ONE - {1'b0, f};
    sf            = {{(FPROD_W-SCL_W){1'b0}}, sat} * {{(FPROD_W-FRAC_W){1'b0}}, f};
    sfc           = {{(FPROD_W-SCL_W){1'b0}}, sat} * {{(FPROD_W-SCL_W){1'b0}}, fc};
    lprod         = {{RECIP_W{1'b0}}, up_data.luma_sum}
                  * {{SUM_W{1'b0}}, LUMA_RECIP};
    s7_nxt.mx     = up_data.mx;
    s7_nxt.mn     = up_data.mn;
    s7_nxt.grey   = up_data.grey;
    s7_nxt.luma   = lprod[LUMA_SHIFT +: PIX_W];
    s7_nxt.sext   = up_data.hq[HUE_W-1:FRAC_W];
    s7_nxt.ap     = HUE_ONE - sat;
    s7_nxt.aq     = HUE_ONE - sf[FPROD_W-1:FRAC_W];
    s7_nxt.at     = HUE_ONE - sfc[FPROD_W-1:FRAC_W];
  end

  // Stage 8: scale by value, pick channels by sextant; a grey target gives the luma, a black or white pixel stays so.
  always_comb begin
    v  = s7_r.mx;
    pp = {{SCL_W{1'b0}}, v} * {{PIX_W{1'b0}}, s7_r.ap};
    qp = {{SCL_W{1'b0}}, v} * {{PIX_W{1'b0}}, s7_r.aq};
    tp = {{SCL_W{1'b0}}, v} * {{PIX_W{1'b0}}, s7_r.at};
    p  = pp[FRAC_W +: PIX_W];
    q  = qp[FRAC_W +: PIX_W];
    t  = tp[FRAC_W +: PIX_W];
    if (s7_r.grey) begin
      red_nxt   = s7_r.luma;
      green_nxt = s7_r.luma;
      blue_nxt  = s7_r.luma;
    end else if (v == '0) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else if (s7_r.mn == PIX_MAX) begin
      red_nxt   = PIX_MAX;
      green_nxt = PIX_MAX;
      blue_nxt  = PIX_MAX;
    end else begin
      case (s7_r.sext)
        SXT_RED_YEL: begin red_nxt = v; green_nxt = t; blue_nxt = p; end
        SXT_YEL_GRN: begin red_nxt = q; green_nxt = v; blue_nxt = p; end
        SXT_GRN_CYN: begin red_nxt = p; green_nxt = v; blue_nxt = t; end
        SXT_CYN_BLU: begin red_nxt = p; green_nxt = q; blue_nxt = v; end
        SXT_BLU_MAG: begin red_nxt = t; green_nxt = p; blue_nxt = v; end
        default:     begin red_nxt = v; green_nxt = p; blue_nxt = q; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (rdy7) v7_r <= up_valid;
      if (rdy8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && up_valid) s7_r <= s7_nxt;
    if (rdy8 && v7_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid     = v8_r;
  assign out_ch.out_red   = red_r;
  assign out_ch.out_green = green_r;
  assign out_ch.out_blue  = blue_r;

endmodule

FILE: hdl/pixel_hue_colorize.sv
// Throughput: one item per cycle through eight register stages; each stage
// holds its item only while the stage after it is full and stalled.
// The hue and saturation quotients take 13 restoring steps spread over five stages.
// Reset (rst_n low, synchronous) empties every stage and clears target_r.
module pixel_hue_colorize (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [phc_pkg::TGT_W-1:0] cfg_data,
  phc_in_if.sink                    in_ch,
  phc_out_if.source                 out_ch
);
  import phc_pkg::*;

  logic [TGT_W-1:0] target_r;
  logic             st_valid [DIV_STAGES+1];
  logic             st_ready [DIV_STAGES+1];
  div_t             st_data  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_we) begin
      target_r <= cfg_data;
    end
  end

  phc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .target   (target_r),
    .in_ch    (in_ch),
    .dn_valid (st_valid[0]),
    .dn_data  (st_data[0]),
    .dn_ready (st_ready[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    phc_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_data  (st_data[i]),
      .up_ready (st_ready[i]),
      .dn_valid (st_valid[i+1]),
      .dn_data  (st_data[i+1]),
      .dn_ready (st_ready[i+1])
    );
  end

  phc_rebuild u_rebuild (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st_valid[DIV_STAGES]),
    .up_data  (st_data[DIV_STAGES]),
    .up_ready (st_ready[DIV_STAGES]),
    .out_ch   (out_ch)
  );

endmodule
